FILE: hdl/fdl_pkg.sv
// Shared types and constants of the FIR filter delay line unit.
`timescale 1ns / 1ps
package fdl_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int IDX_WIDTH    = 5;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;

  // Codes of the kind field.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [IDX_WIDTH-1:0]           tap_index;
    logic signed [COEF_WIDTH-1:0]   tap_value;
  } fdl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;
  } fdl_out_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic                         shift;
    logic                         coef_we;
    logic signed [COEF_WIDTH-1:0] coef;
  } fdl_cell_ctl_t;

endpackage

FILE: hdl/fdl_cell.sv
// One tap cell: a delay line sample, its coefficient and one multiply-add stage.
`timescale 1ns / 1ps
module fdl_cell #(
  parameter int ACC_W = 37
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fdl_pkg::fdl_cell_ctl_t                 ctl,
  input  logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] smp_in,
  output logic signed [fdl_pkg::SAMPLE_WIDTH-1:0] smp_out,
  input  logic                                   tok_in,
  input  logic signed [ACC_W-1:0]                acc_in,
  output logic                                   tok_out,
  output logic signed [ACC_W-1:0]                acc_out
);
  import fdl_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] smp_r;
  logic signed [COEF_WIDTH-1:0]   coef_r;
  logic signed [PROD_WIDTH-1:0]   prod;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_nxt;
  logic                           tok_r;

  assign prod    = smp_r * coef_r;
  assign acc_nxt = acc_in + {{(ACC_W-PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r  <= '0;
      coef_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      if (ctl.shift) begin
        smp_r <= smp_in;
      end
      if (ctl.coef_we) begin
        coef_r <= ctl.coef;
      end
      tok_r <= tok_in;
    end
  end

  // The partial sum is payload; the token tells when it means something.
  always_ff @(posedge clk) begin
    if (tok_in) begin
      acc_r <= acc_nxt;
    end
  end

  assign smp_out = smp_r;
  assign tok_out = tok_r;
  assign acc_out = acc_r;

endmodule

FILE: hdl/fdl_round_sat.sv
// Rounds the finished sum to nearest, shifts it to Q15 and saturates it.
`timescale 1ns / 1ps
module fdl_round_sat #(
  parameter int ACC_W = 37
) (
  input  logic signed [ACC_W-1:0] acc,
  output fdl_pkg::fdl_out_t       res
);
  import fdl_pkg::*;

  localparam logic signed [ACC_W:0] RND  = (ACC_W+1)'(2 ** (COEF_WIDTH - 2));
  localparam logic signed [ACC_W:0] YMAX = (ACC_W+1)'(2 ** (SAMPLE_WIDTH - 1) - 1);
  localparam logic signed [ACC_W:0] YMIN = -(ACC_W+1)'(2 ** (SAMPLE_WIDTH - 1));

  logic signed [ACC_W:0] sum;
  logic signed [ACC_W:0] y;

  assign sum = {acc[ACC_W-1], acc} + RND;
  assign y   = sum >>> (COEF_WIDTH - 1);

  always_comb begin
    if (y > YMAX) begin
      res.filtered = YMAX[SAMPLE_WIDTH-1:0];
      res.clipped  = 1'b1;
    end else if (y < YMIN) begin
      res.filtered = YMIN[SAMPLE_WIDTH-1:0];
      res.clipped  = 1'b1;
    end else begin
      res.filtered = y[SAMPLE_WIDTH-1:0];
      res.clipped  = 1'b0;
    end
  end

endmodule

FILE: hdl/fir_filter_delay_line_unit.sv
// Top level of the FIR filter delay line unit: cell chain, sequencer and output stage.
`timescale 1ns / 1ps
// Direct-form FIR filter built as a row of TAPS identical cells. Each cell keeps one
// delay line sample and one Q1.15 coefficient; both are zero after reset. A sample
// transfer (kind 0) shifts every cell's sample one place down the row and puts the new
// sample in the first cell. In the next cycle a partial sum starts at the first cell and
// walks down the row, one cell per clock, each cell adding its sample times its
// coefficient. The finished sum is rounded to nearest (ties upward), shifted right by
// 15, saturated to 16 bits and flagged in clipped when saturation happened. A
// coefficient transfer (kind 1) writes the tap named by tap_index and gives no result; an
// index of TAPS or more is ignored. The walk of the partial sum through the row sets
// the rate: no new item is taken until a sample's sum has left the row and its result has
// left the holding register. Coefficient transfers go one per cycle while no sample is in
// flight and the holding register is empty. A finished result waits in that register, so
// one more sample can be taken while the output register still waits for its transfer.
module fir_filter_delay_line_unit #(
  parameter int TAPS = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fdl_pkg::fdl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fdl_pkg::fdl_out_t out_data
);
  import fdl_pkg::*;

  // Exact sum width: one full product plus growth over all taps.
  localparam int ACC_W = PROD_WIDTH + $clog2(TAPS);

  logic in_fire;
  logic smp_fire;
  logic coef_fire;

  // Sequencer state: start of the sum walk and sample in flight.
  logic start_r;
  logic busy_r;
  logic busy_nxt;

  // Holding register between the end of the row and the output register.
  logic     pend_valid_r;
  fdl_out_t pend_data_r;
  logic     out_valid_r;
  fdl_out_t out_data_r;

  fdl_cell_ctl_t                  ctl  [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp  [TAPS+1];
  logic signed [ACC_W-1:0]        acc  [TAPS+1];
  logic [TAPS:0]                  tok;
  logic                           tail_tok;
  fdl_out_t                       rs_res;

  assign in_ready  = !busy_r && !pend_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign smp_fire  = in_fire && (in_data.kind == KIND_SAMPLE);
  assign coef_fire = in_fire && (in_data.kind == KIND_COEF);

  assign smp[0]   = in_data.sample_in;
  assign acc[0]   = '0;
  assign tok[0]   = start_r;
  assign tail_tok = tok[TAPS];

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    always_comb begin
      ctl[i].shift   = smp_fire;
      ctl[i].coef_we = coef_fire && ({1'b0, in_data.tap_index} == 6'(i));
      ctl[i].coef    = in_data.tap_value;
    end

    fdl_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .smp_in  (smp[i]),
      .smp_out (smp[i+1]),
      .tok_in  (tok[i]),
      .acc_in  (acc[i]),
      .tok_out (tok[i+1]),
      .acc_out (acc[i+1])
    );
  end

  fdl_round_sat #(
    .ACC_W (ACC_W)
  ) u_round_sat (
    .acc (acc[TAPS]),
    .res (rs_res)
  );

  // A sample stays in flight from its transfer until its sum leaves the row.
  always_comb begin
    busy_nxt = busy_r;
    if (smp_fire) begin
      busy_nxt = 1'b1;
    end else if (tail_tok) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= 1'b0;
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      start_r <= smp_fire;
      busy_r  <= busy_nxt;
      if (!out_valid_r || out_ready) begin
        out_valid_r <= pend_valid_r;
      end
      if (tail_tok) begin
        pend_valid_r <= 1'b1;
      end else if (!out_valid_r || out_ready) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail_tok) begin
      pend_data_r <= rs_res;
    end
    if ((!out_valid_r || out_ready) && pend_valid_r) begin
      out_data_r <= pend_data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finished sum must never land on a result that still waits in the holding stage.
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    tail_tok |-> !pend_valid_r)
    else $error("sum finished while holding register was full");

  // At most one partial sum travels through the row.
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one partial sum in the cell row");

  // No new item may be taken while a partial sum is still in the row.
  a_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (tok == '0))
    else $error("input ready while a sum is in flight");

  // Each sample transfer starts exactly one walk on the next cycle.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    smp_fire |=> (start_r && busy_r))
    else $error("sample transfer did not start the sum walk");

endmodule

FILE: dv/fir_filter_delay_line_unit_test.sv
// Self-checking testbench of the FIR filter delay line unit with its own filter predictor.
`timescale 1ns / 1ps
// The testbench drives sample and coefficient transfers into the unit. It keeps its own
// copy of the delay line and of the coefficient taps, and it works out the filter output
// for every accepted sample. The checker process compares each output transfer field by
// field with the oldest expected output.
//
// The run has a short directed part and then a long random part:
//  - zero coefficients after reset,
//  - the first and last taps at their extremes, with out of range tap indexes,
//  - saturation at both ends of the output range,
//  - rounding ties on both signs,
//  - random traffic under three idling patterns,
//  - a long output stall that fills the unit and stalls its input.
// Unused fields always carry random values, so that the unit is seen to ignore them.
module fir_filter_delay_line_unit_test;
  import fdl_pkg::*;

  localparam int TAPS           = 17;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = TAPS + 10;
  localparam int STALL_CYCLES   = 400;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fdl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  fdl_out_t out_data;

  // Percent of cycles in which the sender or the receiver holds back.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // A test asks for a long output stall here; the receiver process counts it down.
  int unsigned stall_request = 0;
  int unsigned stall_left = 0;

  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Predictor state: the delay line and the coefficient taps.
  logic signed [SAMPLE_WIDTH-1:0] line_samples [TAPS];
  logic signed [COEF_WIDTH-1:0]   tap_coefs [TAPS];
  fdl_out_t                       expected_outputs [$];

  fir_filter_delay_line_unit #(
    .TAPS(TAPS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Updates the predictor with one accepted transfer. A coefficient transfer writes its
  // tap when the index is in range. A sample transfer shifts the line, forms the exact
  // sum of products, rounds it half up, shifts it down by 15 and saturates it.
  task automatic predict_transfer(input fdl_in_t item);
    longint   acc;
    longint   rounded;
    fdl_out_t res;
    if (item.kind == KIND_COEF) begin
      if (item.tap_index < TAPS) begin
        tap_coefs[item.tap_index] = item.tap_value;
      end
    end else begin
      for (int i = TAPS - 1; i > 0; i--) begin
        line_samples[i] = line_samples[i - 1];
      end
      line_samples[0] = item.sample_in;
      acc = 0;
      for (int i = 0; i < TAPS; i++) begin
        acc += longint'(line_samples[i]) * longint'(tap_coefs[i]);
      end
      // The arithmetic shift of a signed longint floors, as the rounding needs.
      rounded = (acc + (longint'(1) <<< (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
      res.clipped = 1'b0;
      if (rounded > longint'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
        rounded     = (1 << (SAMPLE_WIDTH - 1)) - 1;
        res.clipped = 1'b1;
      end else if (rounded < -longint'(1 << (SAMPLE_WIDTH - 1))) begin
        rounded     = -longint'(1 << (SAMPLE_WIDTH - 1));
        res.clipped = 1'b1;
      end
      res.filtered = rounded[SAMPLE_WIDTH-1:0];
      expected_outputs.push_back(res);
    end
  endtask

  // Offers one item with random gaps before it and returns at the falling edge after
  // its transfer. The valid stays high, so a back-to-back item never drops it.
  task automatic send_item(input fdl_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_transfer(item);
    @(negedge clk);
  endtask

  // Item builders; the fields that the kind leaves unused get random values.
  function automatic fdl_in_t sample_item(input logic signed [SAMPLE_WIDTH-1:0] value);
    fdl_in_t item;
    item.kind      = KIND_SAMPLE;
    item.sample_in = value;
    item.tap_index = IDX_WIDTH'($urandom);
    item.tap_value = COEF_WIDTH'($urandom);
    return item;
  endfunction

  function automatic fdl_in_t coef_item(input logic [IDX_WIDTH-1:0] index,
                                        input logic signed [COEF_WIDTH-1:0] value);
    fdl_in_t item;
    item.kind      = KIND_COEF;
    item.sample_in = SAMPLE_WIDTH'($urandom);
    item.tap_index = index;
    item.tap_value = value;
    return item;
  endfunction

  // Random 16-bit word with extra weight on the extremes, zero and small magnitudes,
  // so that both saturated and ordinary outputs turn up often.
  function automatic logic signed [15:0] random_word();
    logic signed [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 7))
      0: w = 16'sh7fff;
      1: w = 16'sh8000;
      2: w = '0;
      3, 4: ;
      default: w = w >>> $urandom_range(1, 12);
    endcase
    return w;
  endfunction

  // The receiver stalls at random, or for a long stretch when a test asks for one.
  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Each output transfer is checked against the oldest expected output.
  always @(posedge clk) begin
    fdl_out_t want;
    if (out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        $display("%0t: output transfer with nothing expected, actual filtered %0d clipped %0b",
                 $time, out_data.filtered, out_data.clipped);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_data.filtered !== want.filtered) begin
          $display("%0t: filtered mismatch, expected %0d actual %0d",
                   $time, want.filtered, out_data.filtered);
          error_count++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped mismatch, expected %0b actual %0b",
                   $time, want.clipped, out_data.clipped);
          error_count++;
        end
      end
    end
  end

  // The watchdog ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d outputs outstanding",
               $time, expected_outputs.size());
      $display("fir_filter_delay_line_unit_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apply_reset();
    for (int i = 0; i < TAPS; i++) begin
      line_samples[i] = '0;
      tap_coefs[i]    = '0;
    end
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
  endtask

  // With all coefficients zero after reset even full-scale samples give zero.
  task automatic test_zero_coefficients();
    send_item(sample_item(16'sh7fff));
    send_item(sample_item(16'sh8000));
  endtask

  // The first and last taps at their extremes; indexes past the last tap are ignored.
  task automatic test_tap_extremes();
    send_item(coef_item(5'd0, 16'sh7fff));
    send_item(coef_item(IDX_WIDTH'(TAPS), 16'sh1234));
    send_item(coef_item(5'd31, 16'sh7fff));
    send_item(coef_item(IDX_WIDTH'(TAPS - 1), 16'sh8000));
    send_item(sample_item(16'sh7fff));
    send_item(sample_item(16'sh8000));
  endtask

  // Two full-scale taps push the sum past both ends of the output range.
  task automatic test_saturation();
    send_item(coef_item(5'd1, 16'sh7fff));
    send_item(sample_item(16'sh7fff));
    send_item(sample_item(16'sh7fff));
    send_item(sample_item(16'sh8000));
    send_item(sample_item(16'sh8000));
  endtask

  // With a single tap of one LSB, a half LSB rounds up on both signs.
  task automatic test_rounding_ties();
    send_item(coef_item(5'd1, 16'sh0000));
    send_item(coef_item(IDX_WIDTH'(TAPS - 1), 16'sh0000));
    send_item(coef_item(5'd0, 16'sh0001));
    send_item(sample_item(16'sh4000));
    send_item(sample_item(-16'sh4000));
    send_item(sample_item(-16'sh4001));
  endtask

  // Random traffic: mostly samples, some tap writes, a few of them out of range.
  // Ignored tap writes are not counted.
  task automatic test_random_traffic(input int unsigned count);
    fdl_in_t     item;
    int unsigned done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 9) == 0) begin
          item = coef_item(IDX_WIDTH'($urandom_range(TAPS, 31)), random_word());
        end else begin
          item = coef_item(IDX_WIDTH'($urandom_range(0, TAPS - 1)), random_word());
          done++;
        end
      end else begin
        item = sample_item(random_word());
        done++;
      end
      send_item(item);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering samples,
  // so the unit fills up and stalls its input until the receiver comes back.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = STALL_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_item(sample_item(random_word()));
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fir_filter_delay_line_unit_test: PASS");
    end else begin
      $display("fir_filter_delay_line_unit_test: FAIL");
    end
    $finish;
  endtask

  initial begin
    apply_reset();
    test_zero_coefficients();
    test_tap_extremes();
    test_saturation();
    test_rounding_ties();
    send_idle_pct = 6;
    recv_idle_pct = 84;
    test_random_traffic(430);
    send_idle_pct = 84;
    recv_idle_pct = 6;
    test_random_traffic(430);
    test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(410);
    finish_run();
  end

endmodule
